// ===== hw/rtl/pts_pkg.sv =====
// package for the periodic task tick scheduler
// sizes, opcode / kind / status codes and the slot memory entry type
// no dependencies
`timescale 1ns / 1ps

package pts_pkg;

    localparam int NUM_TASKS   = 8;
    localparam int COUNT_WIDTH = 16;

    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_IDX_W = $clog2(NUM_TASKS + 1);

    localparam int OPCODE_W = 3;
    localparam int TASK_W   = 5;
    localparam int FIELD_W  = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_CREATE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PAUSE  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_RESUME = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd4;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_TAKEN      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_HANDLER = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE      = 2'd3;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] period;
        logic [COUNT_WIDTH-1:0] countdown;
    } entry_t;

endpackage

// ===== hw/rtl/pts_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/periodic_task_tick_scheduler.sv =====
// periodic task tick scheduler top level
// depends on pts_pkg and pts_ram
`timescale 1ns / 1ps

// usage
// s_axis carries commands: tuser is the opcode (tick, create, pause, resume,
// delete), tdata the slot index, handler flag, period and first delay.
// m_axis carries results: tuser is the kind (status, task due, tick done),
// tdata the slot and status, tlast marks the final result of a command.
// create, pause, resume and delete (and unknown opcodes) answer with one
// status transaction loaded into the output register in the accept cycle;
// such commands can be taken every cycle while the receiver keeps up.
// a tick walks the slot memory through its single read port, one slot per
// cycle while the receiver keeps up, with the write-back of slot i
// overlapping the read of slot i+1: due transactions follow in slot order
// and the done transaction is loaded once the walk ends; the next command
// is taken in the cycle after the done load at the earliest.
// when the receiver stalls, the walk holds on a due slot until the output
// register frees up; nothing is dropped.
// reset clears the valid and paused flags, empties the output register and
// returns to idle; slot period and countdown live in memory and are written
// by create before any use.

module periodic_task_tick_scheduler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // task_index[4:0], handler_present[5], period[21:6], first_delay[37:22]
    input  logic [pts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode[2:0]
    input  logic [pts_pkg::OPCODE_W-1:0]    s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slot[4:0], status[6:5]
    output logic [pts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // kind[1:0]
    output logic [pts_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int NT  = pts_pkg::NUM_TASKS;
    localparam int CW  = pts_pkg::COUNT_WIDTH;
    localparam int IW  = pts_pkg::IDX_W;
    localparam int CIW = pts_pkg::CNT_IDX_W;
    localparam int TW  = pts_pkg::TASK_W;
    localparam int FW  = pts_pkg::FIELD_W;

    logic [1:0]     state_reg, state_next;
    logic [CIW-1:0] rd_idx_reg, rd_idx_next;
    logic           ev_vld_reg, ev_vld_next;
    logic [IW-1:0]  ev_idx_reg, ev_idx_next;
    logic [NT-1:0]  valid_reg, valid_next;
    logic [NT-1:0]  paused_reg, paused_next;

    logic                          out_valid_reg, out_valid_next;
    logic [pts_pkg::KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [TW-1:0]                 out_slot_reg, out_slot_next;
    logic [pts_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_load;

    logic                      ram_we;
    logic [IW-1:0]             ram_wr_addr;
    pts_pkg::entry_t           ram_wr_data;
    logic                      ram_re;
    logic [IW-1:0]             ram_rd_addr;
    pts_pkg::entry_t           ram_rd_data;

    logic [pts_pkg::OPCODE_W-1:0] in_opcode;
    logic [TW-1:0]                in_task;
    logic                         in_handler;
    logic [FW-1:0]                in_period;
    logic [FW-1:0]                in_delay;
    logic                         in_accept;
    logic                         in_range;
    logic [IW-1:0]                op_idx;

    logic out_free;
    logic ev_active;
    logic ev_due;
    logic ev_go;
    logic advance;

    assign in_opcode  = s_axis_tuser;
    assign in_task    = s_axis_tdata[4:0];
    assign in_handler = s_axis_tdata[5];
    assign in_period  = s_axis_tdata[21:6];
    assign in_delay   = s_axis_tdata[37:22];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_range      = ((TW + 1)'(in_task) < (TW + 1)'(NT));
    assign op_idx        = in_task[IW-1:0];

    assign ev_active = valid_reg[ev_idx_reg] && !paused_reg[ev_idx_reg];
    assign ev_due    = ev_active && (ram_rd_data.countdown == '0);
    assign ev_go     = !ev_due || out_free;
    assign advance   = !ev_vld_reg || ev_go;

    pts_ram #(
        .WIDTH ($bits(pts_pkg::entry_t)),
        .DEPTH (NT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        ev_vld_next     = ev_vld_reg;
        ev_idx_next     = ev_idx_reg;
        valid_next      = valid_reg;
        paused_next     = paused_reg;
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = ev_idx_reg;
        ram_wr_data     = ram_rd_data;
        ram_re          = 1'b0;
        ram_rd_addr     = rd_idx_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_opcode == pts_pkg::OP_TICK)
                    begin
                        state_next  = ST_TICK;
                        rd_idx_next = '0;
                        ev_vld_next = 1'b0;
                    end
                    else
                    begin
                        out_load        = 1'b1;
                        out_kind_next   = pts_pkg::KIND_STATUS;
                        out_slot_next   = in_task;
                        out_status_next = pts_pkg::STAT_OK;
                        out_last_next   = 1'b1;
                        if (!in_range)
                        begin
                            out_status_next = pts_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            case (in_opcode)
                                pts_pkg::OP_CREATE:
                                begin
                                    if (!in_handler)
                                    begin
                                        out_status_next = pts_pkg::STAT_NO_HANDLER;
                                    end
                                    else if (valid_reg[op_idx])
                                    begin
                                        out_status_next = pts_pkg::STAT_TAKEN;
                                    end
                                    else
                                    begin
                                        valid_next[op_idx]    = 1'b1;
                                        paused_next[op_idx]   = 1'b0;
                                        ram_we                = 1'b1;
                                        ram_wr_addr           = op_idx;
                                        ram_wr_data.period    = CW'(in_period);
                                        ram_wr_data.countdown = CW'(in_delay);
                                    end
                                end
                                pts_pkg::OP_PAUSE:
                                begin
                                    paused_next[op_idx] = 1'b1;
                                end
                                pts_pkg::OP_RESUME:
                                begin
                                    paused_next[op_idx] = 1'b0;
                                end
                                pts_pkg::OP_DELETE:
                                begin
                                    valid_next[op_idx] = 1'b0;
                                end
                                default:
                                begin
                                    out_status_next = pts_pkg::STAT_RANGE;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_TICK:
            begin
                if (ev_vld_reg && ev_go && ev_active)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = ev_idx_reg;
                    if (ev_due)
                    begin
                        ram_wr_data.countdown = ram_rd_data.period - 1'b1;
                        out_load        = 1'b1;
                        out_kind_next   = pts_pkg::KIND_DUE;
                        out_slot_next   = TW'(ev_idx_reg);
                        out_status_next = pts_pkg::STAT_OK;
                        out_last_next   = 1'b0;
                    end
                    else
                    begin
                        ram_wr_data.countdown = ram_rd_data.countdown - 1'b1;
                    end
                end
                if (advance)
                begin
                    if (rd_idx_reg < CIW'(NT))
                    begin
                        ram_re      = 1'b1;
                        rd_idx_next = rd_idx_reg + 1'b1;
                        ev_vld_next = 1'b1;
                        ev_idx_next = rd_idx_reg[IW-1:0];
                    end
                    else
                    begin
                        ev_vld_next = 1'b0;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = pts_pkg::KIND_DONE;
                    out_slot_next   = '0;
                    out_status_next = pts_pkg::STAT_OK;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            ev_vld_reg    <= 1'b0;
            valid_reg     <= '0;
            paused_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            ev_vld_reg    <= ev_vld_next;
            valid_reg     <= valid_next;
            paused_reg    <= paused_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_idx_reg     <= ev_idx_next;
        out_kind_reg   <= out_kind_next;
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {1'b0, out_status_reg, out_slot_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_no_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_wr_addr != ram_rd_addr))
        else $error("slot memory read and write hit the same entry");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten while a result is pending");

    a_eval_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ev_vld_reg |-> (state_reg == ST_TICK))
        else $error("slot evaluation outside a tick walk");

    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!ev_vld_reg && (rd_idx_reg == CIW'(NT))))
        else $error("tick finished before all slots were walked");
`endif

endmodule
